// ----- rtl/msl_pkg.sv -----
// Shared constants and types for the multi-channel slew limiter.
`default_nettype none

package msl_pkg;

    // Channel count and derived index width
    localparam int CHANNELS = 8;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths fixed by the interface
    localparam int OP_W      = 3;
    localparam int CHAN_W    = 3;
    localparam int VAL_W     = 16;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;
    localparam int PULSE_W   = 16;

    // Full-scale value; the scale is a divide by 2**FS_SHIFT
    localparam int FULL_SCALE = 1024;
    localparam int FS_SHIFT   = $clog2(FULL_SCALE);

    // Command queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_AUTO   = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_MANUAL = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_IDLE   = 3'd3;
    localparam logic [OP_W-1:0] OP_STOP_ALL   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_PER_MS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFFSET = 1'd1;

    localparam logic [CFG_W-1:0] PULSE_PER_MS_RESET = 12'd1600;
    localparam logic [CFG_W-1:0] PULSE_OFFSET_RESET = 12'd1600;

    // One classified command on its way from front to back
    typedef struct packed {
        logic [OP_W-1:0]         op;
        logic [CH_IDX_W-1:0]     chan;
        logic signed [VAL_W-1:0] target;
        logic                    manual_enable;
        logic signed [VAL_W-1:0] step_size;
        logic [VAL_W-1:0]        interval_ticks;
        logic                    armed;
    } cmd_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } seq_state_t;

endpackage

`default_nettype wire

// ----- rtl/multi_channel_esc_slew_limiter_unit.sv -----
// Top level of the multi-channel slew limiter with PWM pulse conversion.
//
//  channel   direction  handshake              payload
//  in        to block   in_valid / in_ready    op, channel, target, manual_enable,
//                                              step_size, interval_ticks, armed
//  out       from block out_valid / out_ready  out_channel, pulse_count,
//                                              channel_value, out_of_range,
//                                              any_out_of_range, last
//  cfg       to block   cfg_write_en           cfg_index, cfg_data
//
// A tick in the channel engine is started from idle, then runs one channel per cycle
// through the shared update logic while the output is not stalled; each set or stop
// command is executed in the idle state.
// A channel's result is registered in the product register, then the output register,
// before it is presented.
// A four-entry command queue lets the input keep accepting while the engine runs.
// Reset clears all channel state and loads both configuration registers with 1600.
// A stalled output holds the tick sequencer and the result pipeline; the queue then
// fills and in_ready drops.
`default_nettype none

module multi_channel_esc_slew_limiter_unit
    import msl_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_W-1:0]        cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic [CHAN_W-1:0]       channel,
    input  wire logic signed [VAL_W-1:0] target,
    input  wire logic                    manual_enable,
    input  wire logic signed [VAL_W-1:0] step_size,
    input  wire logic [VAL_W-1:0]        interval_ticks,
    input  wire logic                    armed,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [CHAN_W-1:0]            out_channel,
    output logic [PULSE_W-1:0]           pulse_count,
    output logic signed [VAL_W-1:0]      channel_value,
    output logic                         out_of_range,
    output logic                         any_out_of_range,
    output logic                         last
);

    logic q_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic q_valid;
    cmd_t q_cmd;

    // Classify and enqueue items
    msl_front u_front
    (
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .channel        (channel),
        .target         (target),
        .manual_enable  (manual_enable),
        .step_size      (step_size),
        .interval_ticks (interval_ticks),
        .armed          (armed),
        .q_full         (q_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    // Decouple front from engine
    msl_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .pop_cmd  (q_cmd)
    );

    // Run commands and ticks
    msl_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .q_valid          (q_valid),
        .q_cmd            (q_cmd),
        .pop              (pop),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_channel      (out_channel),
        .pulse_count      (pulse_count),
        .channel_value    (channel_value),
        .out_of_range     (out_of_range),
        .any_out_of_range (any_out_of_range),
        .last             (last)
    );

endmodule

`default_nettype wire

// ----- rtl/msl_front.sv -----
// Front end: accept items, drop ignored ones, and push commands to the queue.
`default_nettype none

module msl_front
    import msl_pkg::*;
(
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [OP_W-1:0]         op,
    input  wire logic [CHAN_W-1:0]       channel,
    input  wire logic signed [VAL_W-1:0] target,
    input  wire logic                    manual_enable,
    input  wire logic signed [VAL_W-1:0] step_size,
    input  wire logic [VAL_W-1:0]        interval_ticks,
    input  wire logic                    armed,
    input  wire logic                    q_full,
    output logic                         push,
    output cmd_t                         push_cmd
);

    logic chan_ok;
    logic keep;

    // Accept whenever the queue has room, even for items that are dropped
    assign in_ready = !q_full;
    assign chan_ok  = (32'(channel) < CHANNELS);

    // Classify: keep ticks and stop-all, keep channel ops on a real channel
    always_comb
    begin
        case (op)
            OP_TICK:       keep = 1'b1;
            OP_STOP_ALL:   keep = 1'b1;
            OP_SET_AUTO:   keep = chan_ok;
            OP_SET_MANUAL: keep = chan_ok;
            OP_SET_IDLE:   keep = chan_ok;
            default:       keep = 1'b0;
        endcase
    end

    assign push = in_valid && in_ready && keep;

    always_comb
    begin
        push_cmd.op             = op;
        push_cmd.chan           = CH_IDX_W'(channel);
        push_cmd.target         = target;
        push_cmd.manual_enable  = manual_enable;
        push_cmd.step_size      = step_size;
        push_cmd.interval_ticks = (interval_ticks == '0) ? VAL_W'(1) : interval_ticks;
        push_cmd.armed          = armed;
    end

endmodule

`default_nettype wire

// ----- rtl/msl_queue.sv -----
// Short command queue between the front end and the channel engine.
`default_nettype none

module msl_queue
    import msl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      q_valid,
    output cmd_t      pop_cmd
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/msl_back.sv -----
// Back end: channel state, per-channel tick sequencer and pulse pipeline.
`default_nettype none

module msl_back
    import msl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data,
    input  wire logic                   q_valid,
    input  wire cmd_t                   q_cmd,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [CHAN_W-1:0]           out_channel,
    output logic [PULSE_W-1:0]          pulse_count,
    output logic signed [VAL_W-1:0]     channel_value,
    output logic                        out_of_range,
    output logic                        any_out_of_range,
    output logic                        last
);

    localparam int DW_W   = VAL_W + 1;
    localparam int PROD_W = VAL_W + CFG_W + 1;
    localparam int QUO_W  = PROD_W - FS_SHIFT;
    localparam int SUM_W  = QUO_W + 1;

    // Configuration registers
    logic [CFG_W-1:0] ppm_reg;
    logic [CFG_W-1:0] offset_reg;

    // Channel state
    logic signed [VAL_W-1:0] value_reg      [CHANNELS];
    logic signed [VAL_W-1:0] auto_ref_reg   [CHANNELS];
    logic signed [VAL_W-1:0] manual_ref_reg [CHANNELS];
    logic                    manual_reg     [CHANNELS];
    logic signed [VAL_W-1:0] step_limit_reg [CHANNELS];
    logic [VAL_W-1:0]        interval_reg   [CHANNELS];
    logic [VAL_W-1:0]        icount_reg     [CHANNELS];
    logic signed [VAL_W-1:0] idle_reg       [CHANNELS];

    // Sequencer
    seq_state_t          state_reg, state_next;
    logic [CH_IDX_W-1:0] cnt_reg, cnt_next;
    logic                armed_reg;
    logic                any_reg;
    logic                adv;
    logic                issue;
    logic                exec;
    logic                start_tick;
    logic                cnt_last;

    // Per-channel update
    logic signed [VAL_W-1:0] cur;
    logic signed [VAL_W-1:0] ref_val;
    logic                    follow;
    logic                    lim_pos;
    logic                    due;
    logic signed [DW_W-1:0]  diff;
    logic signed [DW_W-1:0]  lim_ext;
    logic signed [DW_W-1:0]  dw;
    logic signed [DW_W-1:0]  moved;
    logic signed [VAL_W-1:0] new_value;
    logic [VAL_W-1:0]        new_icount;
    logic                    new_oor;
    logic                    new_any;
    logic signed [PROD_W-1:0] new_prod;

    // Pipeline stage one
    logic                     s1_valid_reg;
    logic signed [PROD_W-1:0] s1_prod_reg;
    logic [CH_IDX_W-1:0]      s1_chan_reg;
    logic signed [VAL_W-1:0]  s1_value_reg;
    logic                     s1_oor_reg;
    logic                     s1_any_reg;
    logic                     s1_last_reg;

    // Pulse conversion
    logic signed [PROD_W-1:0] rounded;
    logic signed [QUO_W-1:0]  quo;
    logic signed [SUM_W-1:0]  psum;
    logic [PULSE_W-1:0]       pulse_sat;

    // Output register
    logic                    out_valid_reg;
    logic [CHAN_W-1:0]       out_channel_reg;
    logic [PULSE_W-1:0]      pulse_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic                    out_oor_reg;
    logic                    out_any_reg;
    logic                    out_last_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppm_reg    <= PULSE_PER_MS_RESET;
            offset_reg <= PULSE_OFFSET_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PULSE_PER_MS: ppm_reg    <= cfg_data;
                REG_PULSE_OFFSET: offset_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Global stall: every stage moves when the output register can take data
    assign adv        = !out_valid_reg || out_ready;
    assign exec       = (state_reg == ST_IDLE) && q_valid;
    assign pop        = exec;
    assign start_tick = exec && (q_cmd.op == OP_TICK);
    assign issue      = (state_reg == ST_RUN) && adv;
    assign cnt_last   = (cnt_reg == CH_IDX_W'(CHANNELS - 1));

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start_tick)
                begin
                    state_next = ST_RUN;
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            armed_reg <= 1'b0;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (start_tick)
            begin
                armed_reg <= q_cmd.armed;
                any_reg   <= 1'b0;
            end
            else if (issue)
            begin
                any_reg <= new_any;
            end
        end
    end

    // Move the current channel toward its reference
    always_comb
    begin
        cur       = value_reg[cnt_reg];
        ref_val   = manual_reg[cnt_reg] ? manual_ref_reg[cnt_reg] : auto_ref_reg[cnt_reg];
        follow    = armed_reg || manual_reg[cnt_reg];
        lim_pos   = (step_limit_reg[cnt_reg] > 0);
        due       = (icount_reg[cnt_reg] >= interval_reg[cnt_reg]);
        diff      = DW_W'(ref_val) - DW_W'(cur);
        lim_ext   = DW_W'(step_limit_reg[cnt_reg]);
        dw        = diff;
        new_icount = icount_reg[cnt_reg];
        if (lim_pos)
        begin
            if (due)
            begin
                if (diff > lim_ext)
                begin
                    dw = lim_ext;
                end
                else if (diff < -lim_ext)
                begin
                    dw = -lim_ext;
                end
                new_icount = '0;
            end
            else
            begin
                dw = '0;
                new_icount = icount_reg[cnt_reg] + 1'b1;
            end
        end
        moved = DW_W'(cur) + dw;
        if (follow)
        begin
            new_value = VAL_W'(moved);
        end
        else
        begin
            new_value  = idle_reg[cnt_reg];
            new_icount = icount_reg[cnt_reg];
        end
        new_oor  = (new_value < 0) || (new_value > VAL_W'(FULL_SCALE));
        new_any  = any_reg || new_oor;
        new_prod = PROD_W'(new_value) * $signed(PROD_W'({1'b0, ppm_reg}));
    end

    // Channel state: commands, stop-all and tick write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                value_reg[i]      <= '0;
                auto_ref_reg[i]   <= '0;
                manual_ref_reg[i] <= '0;
                manual_reg[i]     <= 1'b0;
                step_limit_reg[i] <= '0;
                interval_reg[i]   <= '0;
                icount_reg[i]     <= '0;
                idle_reg[i]       <= '0;
            end
        end
        else if (exec && (q_cmd.op == OP_STOP_ALL))
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                value_reg[i]      <= '0;
                auto_ref_reg[i]   <= '0;
                manual_ref_reg[i] <= '0;
                manual_reg[i]     <= 1'b0;
                step_limit_reg[i] <= '0;
                interval_reg[i]   <= '0;
                icount_reg[i]     <= '0;
            end
        end
        else if (exec)
        begin
            case (q_cmd.op)
                OP_SET_AUTO:
                begin
                    auto_ref_reg[q_cmd.chan] <= q_cmd.target;
                end
                OP_SET_MANUAL:
                begin
                    manual_ref_reg[q_cmd.chan] <= q_cmd.target;
                    manual_reg[q_cmd.chan]     <= q_cmd.manual_enable;
                    step_limit_reg[q_cmd.chan] <= q_cmd.step_size;
                    if (q_cmd.step_size > 0)
                    begin
                        interval_reg[q_cmd.chan] <= q_cmd.interval_ticks;
                    end
                end
                OP_SET_IDLE:
                begin
                    idle_reg[q_cmd.chan] <= q_cmd.target;
                end
                default:
                begin
                end
            endcase
        end
        else if (issue)
        begin
            value_reg[cnt_reg]  <= new_value;
            icount_reg[cnt_reg] <= new_icount;
        end
    end

    // Stage one: hold the product until the stall clears
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_prod_reg  <= new_prod;
            s1_chan_reg  <= cnt_reg;
            s1_value_reg <= new_value;
            s1_oor_reg   <= new_oor;
            s1_any_reg   <= new_any;
            s1_last_reg  <= cnt_last;
        end
    end

    // Divide by full scale toward zero, add offset, saturate
    always_comb
    begin
        rounded = s1_prod_reg;
        if (s1_prod_reg < 0)
        begin
            rounded = s1_prod_reg + PROD_W'(FULL_SCALE - 1);
        end
        quo  = QUO_W'(rounded >>> FS_SHIFT);
        psum = SUM_W'(quo) + $signed(SUM_W'({1'b0, offset_reg}));
        if (psum < 0)
        begin
            pulse_sat = '0;
        end
        else if (psum > $signed(SUM_W'({1'b0, {PULSE_W{1'b1}}})))
        begin
            pulse_sat = '1;
        end
        else
        begin
            pulse_sat = PULSE_W'(psum);
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            out_channel_reg <= CHAN_W'(s1_chan_reg);
            pulse_reg       <= pulse_sat;
            out_value_reg   <= s1_value_reg;
            out_oor_reg     <= s1_oor_reg;
            out_any_reg     <= s1_any_reg;
            out_last_reg    <= s1_last_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_channel      = out_channel_reg;
    assign pulse_count      = pulse_reg;
    assign channel_value    = out_value_reg;
    assign out_of_range     = out_oor_reg;
    assign any_out_of_range = out_any_reg;
    assign last             = out_last_reg;

endmodule

`default_nettype wire

// ----- tb/multi_channel_esc_slew_limiter_unit_test.sv -----
// Self-checking testbench for the multi-channel slew limiter with PWM pulse conversion.
module multi_channel_esc_slew_limiter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import msl_pkg::*;

    localparam int CLK_PERIOD = 8;
    // Longest quiet pause the test makes on its own, before register writes and at the end
    localparam int SETTLE_CYCLES = 24;
    // Far above any stretch without a handshake in a correct run, even at 60% stall
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS_PER_PHASE = 42;

    // Op codes the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic [CHAN_W-1:0]       chan;
        logic signed [VAL_W-1:0] target;
        logic                    man_en;
        logic signed [VAL_W-1:0] step;
        logic [VAL_W-1:0]        interval;
        logic                    armed;
    } slew_cmd_t;

    typedef struct {
        logic [CHAN_W-1:0]       chan;
        logic [PULSE_W-1:0]      pulse;
        logic signed [VAL_W-1:0] value;
        logic                    oor;
        logic                    any_oor;
        logic                    last;
    } pulse_report_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = REG_PULSE_PER_MS;
    logic [CFG_W-1:0]        cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [OP_W-1:0]         op = OP_TICK;
    logic [CHAN_W-1:0]       channel = '0;
    logic signed [VAL_W-1:0] target = '0;
    logic                    manual_enable = 1'b0;
    logic signed [VAL_W-1:0] step_size = '0;
    logic [VAL_W-1:0]        interval_ticks = '0;
    logic                    armed = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [CHAN_W-1:0]       out_channel;
    logic [PULSE_W-1:0]      pulse_count;
    logic signed [VAL_W-1:0] channel_value;
    logic                    out_of_range;
    logic                    any_out_of_range;
    logic                    last;

    // Predicted per-channel state and configuration
    int ch_value[CHANNELS];
    int ch_auto_ref[CHANNELS];
    int ch_manual_ref[CHANNELS];
    bit ch_manual[CHANNELS];
    int ch_step[CHANNELS];
    int ch_interval[CHANNELS];
    int ch_wait[CHANNELS];
    int ch_idle[CHANNELS];
    int cur_pulse_per_ms = PULSE_PER_MS_RESET;
    int cur_pulse_offset = PULSE_OFFSET_RESET;

    pulse_report_t expected_reports[$];

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int failures = 0;
    int items_sent = 0;
    int ticks_sent = 0;
    int reports_checked = 0;
    int settings_used = 0;
    int stalled_cycles = 0;

    multi_channel_esc_slew_limiter_unit i_dut (.*);

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Advance the predicted state by one accepted item and queue the reports it causes
    function automatic void predict_command(input slew_cmd_t c);
        int dw;
        int p;
        int ref_level;
        bit oor;
        bit any_oor;
        pulse_report_t r;
        case (c.op)
            OP_SET_AUTO:
                if (c.chan < CHANNELS)
                    ch_auto_ref[c.chan] = c.target;
            OP_SET_MANUAL:
                if (c.chan < CHANNELS)
                begin
                    ch_manual_ref[c.chan] = c.target;
                    ch_manual[c.chan] = c.man_en;
                    ch_step[c.chan] = c.step;
                    // a zero interval counts as one tick
                    if (c.step > 0)
                        ch_interval[c.chan] = (c.interval == 0) ? 1 : int'(c.interval);
                end
            OP_SET_IDLE:
                if (c.chan < CHANNELS)
                    ch_idle[c.chan] = c.target;
            OP_STOP_ALL:
                // clear everything but the idle levels
                for (int i = 0; i < CHANNELS; i++)
                begin
                    ch_value[i] = 0;
                    ch_auto_ref[i] = 0;
                    ch_manual_ref[i] = 0;
                    ch_manual[i] = 1'b0;
                    ch_step[i] = 0;
                    ch_interval[i] = 0;
                    ch_wait[i] = 0;
                end
            OP_TICK:
            begin
                any_oor = 1'b0;
                for (int i = 0; i < CHANNELS; i++)
                begin
                    if (!(c.armed || ch_manual[i]))
                        ch_value[i] = ch_idle[i];
                    else
                    begin
                        ref_level = ch_manual[i] ? ch_manual_ref[i] : ch_auto_ref[i];
                        dw = ref_level - ch_value[i];
                        // limit the move to one step per interval
                        if (ch_step[i] > 0)
                        begin
                            if (ch_wait[i] >= ch_interval[i])
                            begin
                                if (dw > ch_step[i])
                                    dw = ch_step[i];
                                else if (dw < -ch_step[i])
                                    dw = -ch_step[i];
                                ch_wait[i] = 0;
                            end
                            else
                            begin
                                dw = 0;
                                ch_wait[i]++;
                            end
                        end
                        ch_value[i] += dw;
                    end
                    oor = (ch_value[i] < 0) || (ch_value[i] > FULL_SCALE);
                    any_oor = any_oor || oor;
                    p = ch_value[i] * cur_pulse_per_ms / FULL_SCALE + cur_pulse_offset;
                    if (p < 0)
                        p = 0;
                    else if (p > 65535)
                        p = 65535;
                    r.chan = CHAN_W'(i);
                    r.pulse = PULSE_W'(p);
                    r.value = VAL_W'(ch_value[i]);
                    r.oor = oor;
                    r.any_oor = any_oor;
                    r.last = (i == CHANNELS - 1);
                    expected_reports.push_back(r);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic slew_cmd_t make_cmd(input logic [OP_W-1:0] o, input int ch,
                                           input int tgt, input bit men, input int stp,
                                           input int ivl, input bit arm);
        slew_cmd_t c;
        c.op = o;
        c.chan = CHAN_W'(ch);
        c.target = VAL_W'(tgt);
        c.man_en = men;
        c.step = VAL_W'(stp);
        c.interval = VAL_W'(ivl);
        c.armed = arm;
        return c;
    endfunction

    // Mostly in or near the working range, sometimes anywhere in 16 bits
    function automatic logic signed [VAL_W-1:0] random_level();
        int pick;
        pick = $urandom_range(3);
        if (pick == 0)
            return VAL_W'($urandom);
        return VAL_W'(int'($urandom_range(1400)) - 200);
    endfunction

    function automatic logic signed [VAL_W-1:0] random_step();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return VAL_W'($urandom);
        if (pick == 2)
            return VAL_W'(-int'($urandom_range(1, 32768)));
        return VAL_W'($urandom_range(1, 200));
    endfunction

    function automatic logic [VAL_W-1:0] random_interval();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return VAL_W'($urandom);
        if (pick == 1)
            return '0;
        return VAL_W'($urandom_range(1, 4));
    endfunction

    function automatic slew_cmd_t random_cmd();
        slew_cmd_t c;
        c.op = OP_TICK;
        c.chan = CHAN_W'($urandom_range(CHANNELS - 1));
        c.target = random_level();
        c.man_en = 1'($urandom_range(1));
        c.step = random_step();
        c.interval = random_interval();
        c.armed = 1'($urandom_range(1));
        return c;
    endfunction

    // Present one item, hold it until accepted, then maybe idle a while
    task automatic send_item(input slew_cmd_t c);
        in_valid <= 1'b1;
        op <= c.op;
        channel <= c.chan;
        target <= c.target;
        manual_enable <= c.man_en;
        step_size <= c.step;
        interval_ticks <= c.interval;
        armed <= c.armed;
        do
            @(posedge clk);
        while (!in_ready);
        predict_command(c);
        items_sent++;
        if (c.op == OP_TICK)
            ticks_sent++;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
    endtask

    // Stop sending and wait for every outstanding report
    task automatic hold_until_drained();
        if (in_valid)
            in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_reports.size() != 0);
    endtask

    // Drain, then let trailing set commands clear the engine
    task automatic quiesce();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input int ppm, input int offset);
        cfg_write_en <= 1'b1;
        cfg_index <= REG_PULSE_PER_MS;
        cfg_data <= CFG_W'(ppm);
        @(posedge clk);
        cur_pulse_per_ms = ppm;
        cfg_index <= REG_PULSE_OFFSET;
        cfg_data <= CFG_W'(offset);
        @(posedge clk);
        cur_pulse_offset = offset;
        cfg_write_en <= 1'b0;
        settings_used++;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    // Compare each report with the oldest prediction, then pick the next ready level
    always @(posedge clk)
    begin : report_check
        pulse_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                $error("report for channel %0d with none expected", out_channel);
                failures++;
            end
            else
            begin
                want = expected_reports.pop_front();
                check_field("out_channel", want.chan, out_channel);
                check_field("pulse_count", want.pulse, pulse_count);
                check_field("channel_value", want.value, channel_value);
                check_field("out_of_range", want.oor, out_of_range);
                check_field("any_out_of_range", want.any_oor, any_out_of_range);
                check_field("last", want.last, last);
                reports_checked++;
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Give up when neither channel moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles = 0;
        else
            stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d reports outstanding",
                     stalled_cycles, expected_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Ticks straight out of reset: every channel at zero, pulse at the reset offset
    task automatic test_reset_defaults();
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
        send_item(make_cmd(OP_TICK, 7, 0, 0, 0, 0, 1));
    endtask

    // Field extremes, every op, ignored op codes and stop-all
    task automatic test_range_extremes();
        send_item(make_cmd(OP_SET_AUTO, 0, 32767, 1, 32767, 65535, 1));
        send_item(make_cmd(OP_SET_AUTO, 1, -32768, 0, -32768, 0, 0));
        send_item(make_cmd(OP_SET_AUTO, 2, 1024, 0, 0, 0, 0));
        send_item(make_cmd(OP_SET_AUTO, 3, 1025, 0, 0, 0, 0));
        send_item(make_cmd(OP_SET_AUTO, 4, -1, 0, 0, 0, 0));
        send_item(make_cmd(OP_SET_IDLE, 5, 32767, 0, 0, 0, 0));
        send_item(make_cmd(OP_SET_IDLE, 6, -32768, 0, 0, 0, 0));
        // zero interval with a step behaves as one tick
        send_item(make_cmd(OP_SET_MANUAL, 7, 500, 1, 100, 0, 0));
        // most negative step means no limit; interval not stored
        send_item(make_cmd(OP_SET_MANUAL, 6, -300, 1, -32768, 65535, 0));
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 1));
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
        // largest step and interval on an auto channel
        send_item(make_cmd(OP_SET_MANUAL, 5, 1000, 0, 32767, 65535, 1));
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 1));
        send_item(make_cmd(OP_SPARE_5, 1, 32767, 1, 32767, 65535, 1));
        send_item(make_cmd(OP_SPARE_6, 6, -32768, 1, -32768, 0, 0));
        send_item(make_cmd(OP_SPARE_7, 7, -1, 1, -1, 65535, 1));
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 1));
        send_item(make_cmd(OP_STOP_ALL, 3, 77, 1, 5, 5, 1));
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 1));
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
    endtask

    // Saturation at both ends with the registers at their extremes
    task automatic test_pulse_saturation();
        quiesce();
        write_config(4095, 4095);
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
        quiesce();
        write_config(0, 0);
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
        quiesce();
        write_config(4095, 0);
        send_item(make_cmd(OP_SET_MANUAL, 2, -1, 1, 0, 0, 0));
        send_item(make_cmd(OP_TICK, 0, 0, 0, 0, 0, 0));
    endtask

    // Bursts of set commands followed by ticks, with some noise between them
    task automatic run_slew_bursts(input int n_items);
        int counted;
        int setups;
        int ticks;
        slew_cmd_t c;
        counted = 0;
        while (counted < n_items)
        begin
            if ($urandom_range(99) < 85)
            begin
                setups = $urandom_range(1, 4);
                for (int k = 0; k < setups; k++)
                begin
                    c = random_cmd();
                    case ($urandom_range(2))
                        0: c.op = OP_SET_AUTO;
                        1: c.op = OP_SET_MANUAL;
                        default: c.op = OP_SET_IDLE;
                    endcase
                    send_item(c);
                end
                ticks = $urandom_range(1, 6);
                for (int k = 0; k < ticks; k++)
                begin
                    c = random_cmd();
                    c.op = OP_TICK;
                    c.armed = ($urandom_range(9) != 0);
                    send_item(c);
                end
                counted += setups + ticks;
            end
            else
            begin
                c = random_cmd();
                case ($urandom_range(3))
                    0: c.op = OP_STOP_ALL;
                    1: c.op = OP_SPARE_5 + OP_W'($urandom_range(2));
                    2: c.op = OP_TICK;
                    default: c.op = OP_W'($urandom);
                endcase
                send_item(c);
                if (c.op <= OP_STOP_ALL)
                    counted++;
            end
        end
    endtask

    // Random traffic under each idle pattern, with a new register setting per phase
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            quiesce();
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 0;
                    write_config($urandom_range(4095), $urandom_range(4095));
                end
                1:
                begin
                    sender_idle_pct = 60;
                    recv_stall_pct = 0;
                    write_config(4095, 4095);
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct = 60;
                    write_config($urandom_range(4095), $urandom_range(4095));
                end
                default:
                begin
                    sender_idle_pct = 10;
                    recv_stall_pct = 10;
                    write_config(PULSE_PER_MS_RESET, PULSE_OFFSET_RESET);
                end
            endcase
            run_slew_bursts(RANDOM_ITEMS_PER_PHASE);
        end
    endtask

    // Stop the sender mid-stream until every pending report is out, then resume
    task automatic test_pause_for_results();
        slew_cmd_t c;
        quiesce();
        sender_idle_pct = 0;
        recv_stall_pct = 60;
        write_config(1024, 0);
        for (int k = 0; k < 4; k++)
        begin
            c = random_cmd();
            c.op = OP_SET_MANUAL;
            send_item(c);
            c = random_cmd();
            c.op = OP_TICK;
            send_item(c);
            send_item(c);
            hold_until_drained();
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_range_extremes();
        test_pulse_saturation();
        test_random_traffic();
        test_pause_for_results();

        quiesce();
        $display("Sent %0d items (%0d ticks), checked %0d channel reports, %0d register settings,",
                 items_sent, ticks_sent, reports_checked, settings_used);
        $display("covering range extremes, saturation, idle and stall patterns and a drain pause.");
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
